// File: rtl/u16u8_pkg.sv
package u16u8_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_BYTES       = 6;

  localparam logic REG_ASCII_ONLY = 1'b0;
  localparam logic REG_OUT_LIMIT  = 1'b1;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [20:0] CP_ASCII_MAX   = 21'h00007F;
  localparam logic [20:0] CP_TWO_MAX     = 21'h0007FF;
  localparam logic [20:0] CP_BMP_MAX     = 21'h00FFFF;
  localparam logic [7:0]  BYTE_QMARK     = 8'h3F;
  localparam logic [5:0]  HIGH_SUR_TAG   = 6'b110110;
  localparam logic [5:0]  LOW_SUR_TAG    = 6'b110111;
  localparam logic [4:0]  SUR_TAG        = 5'b11011;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_seq_t;

  // one queued entry: the bytes of one accepted unit in order, then an optional halt result
  typedef struct packed {
    logic [2:0]                n_bytes;
    logic                      halt;
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [15:0]               base;
  } enc_entry_t;

  function automatic utf8_seq_t utf8_encode(input logic [20:0] cp_in, input logic ascii);
    utf8_seq_t  s;
    logic [20:0] cp;
    cp = cp_in;
    s.bytes = '0;
    if (ascii && cp > CP_ASCII_MAX) begin
      cp = {13'b0, BYTE_QMARK};
    end
    if (cp <= CP_ASCII_MAX) begin
      s.len = 3'd1;
      s.bytes[0] = cp[7:0];
    end else if (cp <= CP_TWO_MAX) begin
      s.len = 3'd2;
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= CP_BMP_MAX) begin
      s.len = 3'd3;
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      s.len = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

endpackage

// File: rtl/u16u8_front.sv
module u16u8_front #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ascii_only,
  input  logic [15:0]           out_limit,
  input  logic                  push,
  input  logic [15:0]           code_unit,
  input  logic                  last_unit,
  input  logic                  q_full,
  output logic                  q_wr,
  output u16u8_pkg::enc_entry_t q_entry
);
  import u16u8_pkg::*;

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int EW = LW + 1;
  localparam logic [EW-1:0] CMAX = (EW'(1) << COUNT_WIDTH) - EW'(1);

  logic                   high_pending;
  logic [9:0]             held_high_bits;
  logic [COUNT_WIDTH-1:0] written_count;
  logic                   stopped;

  logic                   high_pending_next;
  logic [9:0]             held_high_bits_next;
  logic [COUNT_WIDTH-1:0] written_count_next;
  logic                   stopped_next;

  logic        accept;
  logic        is_low, is_high, is_sur;
  logic [20:0] supp_cp, e1_cp, e2_cp;
  utf8_seq_t   enc1, enc2;
  logic        e1_act, e2_act, e1_halt, e2_halt, stop1, hold;
  logic [2:0]  n1, n2;
  logic [EW-1:0] limit, lim_raw, cnt_ext, cnt1_ext, sum1, sum2;
  logic [2:0]  idx2;

  assign accept  = push && !q_full;
  assign is_low  = code_unit[15:10] == LOW_SUR_TAG;
  assign is_high = code_unit[15:10] == HIGH_SUR_TAG;
  assign is_sur  = code_unit[15:11] == SUR_TAG;
  assign supp_cp = {1'b0, held_high_bits, code_unit[9:0]} + CP_SUPP_BASE;

  assign lim_raw = EW'(out_limit);
  assign limit   = (lim_raw > CMAX) ? CMAX : lim_raw;
  assign cnt_ext = EW'(written_count);

  assign e1_act  = !stopped && high_pending;
  assign e1_cp   = is_low ? supp_cp : CP_REPLACEMENT;
  assign enc1    = utf8_encode(e1_cp, ascii_only);
  assign sum1    = cnt_ext + EW'(enc1.len);
  assign e1_halt = e1_act && (sum1 > limit);
  assign n1      = (e1_act && !e1_halt) ? enc1.len : 3'd0;
  assign stop1   = stopped || e1_halt;

  assign hold    = !stop1 && !(e1_act && is_low) && is_high && !last_unit;
  assign e2_act  = !stop1 && !(e1_act && is_low) && !(is_high && !last_unit);
  assign e2_cp   = is_sur ? CP_REPLACEMENT : {5'b0, code_unit};
  assign enc2    = utf8_encode(e2_cp, ascii_only);
  assign cnt1_ext = cnt_ext + EW'(n1);
  assign sum2    = cnt1_ext + EW'(enc2.len);
  assign e2_halt = e2_act && (sum2 > limit);
  assign n2      = (e2_act && !e2_halt) ? enc2.len : 3'd0;

  always_comb begin
    q_entry.n_bytes = n1 + n2;
    q_entry.halt    = e1_halt || e2_halt;
    q_entry.base    = cnt_ext[15:0];
    for (int i = 0; i < MAX_BYTES; i++) begin
      idx2 = 3'(i) - n1;
      if (3'(i) < n1) begin
        q_entry.bytes[i] = enc1.bytes[idx2[1:0] + 2'(n1)];
      end else if (idx2 < n2) begin
        q_entry.bytes[i] = enc2.bytes[idx2[1:0]];
      end else begin
        q_entry.bytes[i] = 8'h00;
      end
    end
  end

  assign q_wr = accept && ((n1 + n2) != 3'd0 || e1_halt || e2_halt);

  always_comb begin
    high_pending_next   = high_pending;
    held_high_bits_next = held_high_bits;
    written_count_next  = written_count;
    stopped_next        = stopped;
    if (accept) begin
      if (last_unit) begin
        high_pending_next   = 1'b0;
        held_high_bits_next = '0;
        written_count_next  = '0;
        stopped_next        = 1'b0;
      end else if (!stopped) begin
        high_pending_next  = hold;
        if (hold) begin
          held_high_bits_next = code_unit[9:0];
        end
        written_count_next = written_count + COUNT_WIDTH'(n1) + COUNT_WIDTH'(n2);
        stopped_next       = stop1 || e2_halt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending   <= 1'b0;
      held_high_bits <= '0;
      written_count  <= '0;
      stopped        <= 1'b0;
    end else begin
      high_pending   <= high_pending_next;
      held_high_bits <= held_high_bits_next;
      written_count  <= written_count_next;
      stopped        <= stopped_next;
    end
  end

endmodule

// File: rtl/u16u8_queue.sv
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  u16u8_pkg::enc_entry_t wr_data,
  input  logic                  rd,
  output u16u8_pkg::enc_entry_t rd_data,
  output logic                  full,
  output logic                  empty
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  enc_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr, do_rd;

  assign full    = fill == CW'(DEPTH);
  assign empty   = fill == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// File: rtl/u16u8_back.sv
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  u16u8_pkg::enc_entry_t q_entry,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  has_byte,
  output logic                  last_of_run,
  output logic                  halted,
  output logic [15:0]           bytes_written
);
  import u16u8_pkg::*;

  enc_entry_t  cur;
  logic        cur_valid;
  logic [2:0]  pos;
  logic [15:0] cnt;
  logic [2:0]  total;
  logic        take, load;

  assign total       = cur.n_bytes + 3'(cur.halt);
  assign empty       = !cur_valid;
  assign has_byte    = pos < cur.n_bytes;
  assign halted      = !has_byte;
  assign out_byte    = has_byte ? cur.bytes[pos] : 8'h00;
  assign last_of_run = pos == (total - 3'd1);
  assign bytes_written = cnt + 16'(has_byte);

  assign take = pop && cur_valid;
  assign load = !cur_valid || (take && last_of_run);
  assign q_rd = load && !q_empty;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
      cnt       <= '0;
    end else if (load) begin
      cur_valid <= !q_empty;
      pos       <= '0;
      cnt       <= q_entry.base;
    end else if (take) begin
      pos <= pos + 3'd1;
      cnt <= bytes_written;
    end
  end

endmodule

// File: rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder.
// A transaction's first result passes the queue and the serializer's register.
// Throughput: one result per cycle at the output while pop is held and entries
// are queued; a unit gives 0 to 6 results; units queue while earlier ones drain.
// Reset (rst, synchronous): clears queue and surrogate/count state; ascii_only=1,
// out_limit=65535.
module utf16_to_utf8_transcoder #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        last_of_run,
  output logic        halted,
  output logic [15:0] bytes_written
);
  import u16u8_pkg::*;

  logic        ascii_only;
  logic [15:0] out_limit;
  logic        cfg_wr;

  logic        q_wr, q_rd, q_empty;
  enc_entry_t  wr_entry, rd_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_ASCII_ONLY: prdata = {31'b0, ascii_only};
      REG_OUT_LIMIT:  prdata = {16'b0, out_limit};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_only <= 1'b1;
      out_limit  <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ASCII_ONLY: ascii_only <= pwdata[0];
        REG_OUT_LIMIT:  out_limit  <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  u16u8_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .ascii_only(ascii_only),
    .out_limit (out_limit),
    .push      (push),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_full    (full),
    .q_wr      (q_wr),
    .q_entry   (wr_entry)
  );

  u16u8_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_data(wr_entry),
    .rd     (q_rd),
    .rd_data(rd_entry),
    .full   (full),
    .empty  (q_empty)
  );

  u16u8_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_entry      (rd_entry),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .last_of_run  (last_of_run),
    .halted       (halted),
    .bytes_written(bytes_written)
  );

endmodule
